[rtl/core/lstb_pkg.sv]
package lstb_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned TURN_W  = 6;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CCNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // command codes on cmd_i
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ANNOUNCE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESYNC   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd3;

  localparam logic [TICK_W-1:0] LIMIT_RESET = 16'd200;
  localparam logic [CCNT_W-1:0] COUNT_RESET = 5'd1;

  localparam logic ROLE_SERVER = 1'b0;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_UPDATE,
    OP_REPORT,
    OP_ANNOUNCE,
    OP_START,
    OP_RESYNC,
    OP_NOP
  } lstb_op_e;

  typedef struct packed {
    lstb_op_e            op;
    logic                paused;
    logic [SLOT_W-1:0]   slot;
    logic [TURN_W-1:0]   turn_value;
  } lstb_item_t;

  typedef struct packed {
    logic                valid;
    logic                update_allowed;
    logic [TURN_W-1:0]   turn_now;
    logic [TURN_W-1:0]   server_done_turn;
    logic                all_ready;
    logic                turn_report;
  } lstb_res_t;

endpackage

[rtl/core/lstb_front.sv]
module lstb_front #(
  parameter int unsigned MAX_CLIENTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       lockstep_en_i,
  input  logic [lstb_pkg::CMD_W-1:0] cmd_i,
  input  logic                       paused_i,
  input  logic [lstb_pkg::SLOT_W-1:0] client_slot_i,
  input  logic [lstb_pkg::TURN_W-1:0] turn_value_i,
  output logic                       push_o,
  output lstb_pkg::lstb_item_t       item_o
);
  import lstb_pkg::*;

  lstb_op_e op;
  logic     slot_ok;

  // registered push keeps the decode off the queue write path
  logic       push_q;
  lstb_item_t item_q, item_d;

  assign slot_ok = 32'(client_slot_i) < 32'(MAX_CLIENTS);

  // with lockstep off only update requests do anything
  always_comb begin
    op = OP_NOP;
    case (cmd_i)
      CMD_UPDATE:   op = OP_UPDATE;
      CMD_TICK:     op = lockstep_en_i ? OP_TICK : OP_NOP;
      CMD_REPORT:   op = (lockstep_en_i && slot_ok) ? OP_REPORT : OP_NOP;
      CMD_ANNOUNCE: op = lockstep_en_i ? OP_ANNOUNCE : OP_NOP;
      CMD_START:    op = lockstep_en_i ? OP_START : OP_NOP;
      CMD_RESYNC:   op = lockstep_en_i ? OP_RESYNC : OP_NOP;
      default:      op = OP_NOP;
    endcase
  end

  always_comb begin
    item_d.op         = op;
    item_d.paused     = paused_i;
    item_d.slot       = client_slot_i;
    item_d.turn_value = turn_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= 1'b0;
    end else begin
      push_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign push_o = push_q;
  assign item_o = item_q;

endmodule

[rtl/core/lstb_queue.sv]
module lstb_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'(DEPTH);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

[rtl/core/lstb_back.sv]
module lstb_back #(
  parameter int unsigned MAX_CLIENTS      = 16,
  parameter int unsigned UPDATES_PER_TURN = 6,
  parameter int unsigned TURN_FIRST       = 3,
  parameter int unsigned TURN_LAST        = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lstb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lstb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            item_valid_i,
  input  lstb_pkg::lstb_item_t            item_i,
  output logic                            item_pop_o,
  output logic                            lockstep_en_o,
  output lstb_pkg::lstb_res_t             res_o
);
  import lstb_pkg::*;

  localparam int unsigned IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int unsigned UPD_W = $clog2(UPDATES_PER_TURN + 1);
  localparam logic [UPD_W-1:0]  UPD_MAX = UPD_W'(UPDATES_PER_TURN);
  localparam logic [TURN_W-1:0] T_FIRST = TURN_W'(TURN_FIRST);
  localparam logic [TURN_W-1:0] T_LAST  = TURN_W'(TURN_LAST);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // configuration
  logic                en_q, en_d;
  logic                role_q, role_d;
  logic [TICK_W-1:0]   limit_q, limit_d;
  logic [CCNT_W-1:0]   ccount_q, ccount_d;

  // turn state
  logic [TURN_W-1:0]   turn_q, turn_d;
  logic                run_q, run_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  logic [UPD_W-1:0]    upd_q, upd_d;
  logic [TURN_W-1:0]   sd_q, sd_d;
  logic [TURN_W-1:0]   table_q [MAX_CLIENTS];
  logic [TURN_W-1:0]   table_d [MAX_CLIENTS];

  // sequencer
  logic                state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                all_q, all_d;
  lstb_res_t           res_q, res_d;

  logic [TICK_W-1:0]   ticks_inc;
  logic [TURN_W-1:0]   nxt_turn;
  logic [SW-1:0]       slot_w;
  logic [IDX_W-1:0]    slot_idx;
  logic [31:0]         n_clients;
  logic                pop, emit, do_next, is_upd, grant, fin, srv_p, cli_p, all_now;

  assign pop       = (state_q == ST_IDLE) && item_valid_i;
  assign ticks_inc = (run_q && (ticks_q != '1)) ? ticks_q + 1'b1 : ticks_q;
  assign nxt_turn  = (turn_q < T_LAST) ? turn_q + 1'b1 : T_FIRST;
  assign slot_w    = SW'(item_i.slot);
  assign slot_idx  = slot_w[IDX_W-1:0];
  assign n_clients = (32'(ccount_q) > 32'(MAX_CLIENTS)) ? 32'(MAX_CLIENTS) : 32'(ccount_q);
  assign fin       = run_q && (ticks_inc >= limit_q) && (upd_q == UPD_MAX) &&
                     (sd_q != turn_q);
  assign all_now   = all_q && (table_q[idx_q] == turn_q);

  always_comb begin
    en_d     = en_q;
    role_d   = role_q;
    limit_d  = limit_q;
    ccount_d = ccount_q;
    turn_d   = turn_q;
    run_d    = run_q;
    ticks_d  = ticks_q;
    upd_d    = upd_q;
    sd_d     = sd_q;
    table_d  = table_q;
    state_d  = state_q;
    idx_d    = idx_q;
    all_d    = all_q;
    emit     = 1'b0;
    do_next  = 1'b0;
    is_upd   = 1'b0;
    grant    = 1'b0;
    srv_p    = 1'b0;
    cli_p    = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE: en_d     = cfg_data_i[0];
        CFG_ROLE:   role_d   = cfg_data_i[0];
        CFG_LIMIT:  limit_d  = cfg_data_i[TICK_W-1:0];
        CFG_COUNT:  ccount_d = cfg_data_i[CCNT_W-1:0];
        default:    ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          emit = 1'b1;
          case (item_i.op)
            OP_UPDATE: begin
              is_upd = 1'b1;
              grant  = !en_q || (upd_q < UPD_MAX);
              if (grant && en_q) begin
                upd_d = upd_q + 1'b1;
              end
            end
            OP_REPORT:   table_d[slot_idx] = item_i.turn_value;
            OP_ANNOUNCE: sd_d = item_i.turn_value;
            OP_START: begin
              run_d   = 1'b1;
              ticks_d = '0;
            end
            OP_RESYNC: begin
              run_d   = 1'b0;
              ticks_d = '0;
              turn_d  = T_FIRST;
              sd_d    = '0;
              upd_d   = '0;
              limit_d = LIMIT_RESET;
            end
            OP_TICK: begin
              ticks_d = ticks_inc;
              if (role_q == ROLE_SERVER) begin
                if (!item_i.paused) begin
                  if (fin) begin
                    run_d      = 1'b0;
                    ticks_d    = '0;
                    table_d[0] = turn_q;
                  end
                  if (!(run_q && !fin) && (sd_q != turn_q)) begin
                    if (n_clients == 32'd0) begin
                      sd_d    = turn_q;
                      srv_p   = 1'b1;
                      do_next = 1'b1;
                    end else begin
                      // walk the client table, one entry a cycle
                      state_d = ST_SCAN;
                      idx_d   = '0;
                      all_d   = 1'b1;
                      emit    = 1'b0;
                    end
                  end else if (sd_q == turn_q) begin
                    do_next = 1'b1;
                  end
                end
              end else begin
                if (fin) begin
                  run_d   = 1'b0;
                  ticks_d = '0;
                  cli_p   = 1'b1;
                end
                if (sd_q == turn_q) begin
                  do_next = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (32'(idx_q) + 32'd1 == n_clients) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (all_now) begin
            sd_d    = turn_q;
            srv_p   = 1'b1;
            do_next = 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          all_d = all_now;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_next) begin
      turn_d  = nxt_turn;
      upd_d   = '0;
      run_d   = 1'b1;
      ticks_d = '0;
    end

    res_d                  = res_q;
    res_d.valid            = emit;
    res_d.update_allowed   = is_upd ? grant : (!en_q || (upd_d < UPD_MAX));
    res_d.turn_now         = turn_d;
    res_d.server_done_turn = sd_d;
    res_d.all_ready        = srv_p;
    res_d.turn_report      = cli_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b1;
      role_q    <= ROLE_SERVER;
      limit_q   <= LIMIT_RESET;
      ccount_q  <= COUNT_RESET;
      turn_q    <= T_FIRST;
      run_q     <= 1'b0;
      ticks_q   <= '0;
      upd_q     <= '0;
      sd_q      <= '0;
      for (int i = 0; i < int'(MAX_CLIENTS); i++) begin
        table_q[i] <= '0;
      end
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      all_q     <= 1'b0;
      res_q     <= '0;
    end else begin
      en_q      <= en_d;
      role_q    <= role_d;
      limit_q   <= limit_d;
      ccount_q  <= ccount_d;
      turn_q    <= turn_d;
      run_q     <= run_d;
      ticks_q   <= ticks_d;
      upd_q     <= upd_d;
      sd_q      <= sd_d;
      table_q   <= table_d;
      state_q   <= state_d;
      idx_q     <= idx_d;
      all_q     <= all_d;
      res_q     <= res_d;
    end
  end

  assign item_pop_o    = pop;
  assign lockstep_en_o = en_q;
  assign res_o         = res_q;

endmodule

[rtl/core/lockstep_turn_barrier_unit.sv]
// Lockstep turn barrier. A command is transferred at a rising edge with start high and busy
// low; every command gives exactly one result, shown for one cycle with result_valid_o high.
// The receiver cannot stall, so results must be taken as they come. When nothing is ahead
// of it, a command passes the decode register, the queue and execute on its way to its
// result. Back to back, a command can be transferred while earlier ones are in flight, but
// busy is high for a cycle whenever two commands wait ahead of the execute stage. A server
// tick that has to check the client table holds the execute stage while it reads each of
// the min(client_count, MAX_CLIENTS) table entries in use, one entry a cycle. While that
// scan runs, up to two further commands wait in the decode register and the queue; busy
// stays high while two are waiting. Configuration writes take effect at once and belong in
// idle periods.
// Reset leaves: lockstep on, server role, turn limit 200, one client, turn TURN_FIRST.
module lockstep_turn_barrier_unit #(
  parameter int unsigned MAX_CLIENTS      = 16,
  parameter int unsigned UPDATES_PER_TURN = 6,
  parameter int unsigned TURN_FIRST       = 3,
  parameter int unsigned TURN_LAST        = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [lstb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lstb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // command side
  input  logic                            start,
  output logic                            busy,
  input  logic [lstb_pkg::CMD_W-1:0]      cmd_i,
  input  logic                            paused_i,
  input  logic [lstb_pkg::SLOT_W-1:0]     client_slot_i,
  input  logic [lstb_pkg::TURN_W-1:0]     turn_value_i,
  // result side
  output logic                            result_valid_o,
  output logic                            update_allowed_o,
  output logic [lstb_pkg::TURN_W-1:0]     turn_now_o,
  output logic [lstb_pkg::TURN_W-1:0]     server_done_turn_o,
  output logic                            all_ready_o,
  output logic                            turn_report_o
);
  import lstb_pkg::*;

  localparam int unsigned ITEM_W = $bits(lstb_item_t);

  logic       accept;
  logic       push;
  lstb_item_t front_item;
  logic       q_valid, q_full, pop, lockstep_en;
  logic [ITEM_W-1:0] q_data;
  lstb_item_t back_item;
  lstb_res_t  res;

  // The decode register plus one in-flight slot: hold busy while the queue could overflow.
  logic [1:0] inflight_q, inflight_d;

  assign accept = start && !busy;

  always_comb begin
    inflight_d = inflight_q;
    if (accept && !pop) begin
      inflight_d = inflight_q + 2'd1;
    end else if (pop && !accept) begin
      inflight_d = inflight_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 2'd0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // counts commands in decode plus queue; the queue holds two
  assign busy = (inflight_q == 2'd2) || q_full;

  // front: decode and classify the command
  lstb_front #(
    .MAX_CLIENTS(MAX_CLIENTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .lockstep_en_i (lockstep_en),
    .cmd_i         (cmd_i),
    .paused_i      (paused_i),
    .client_slot_i (client_slot_i),
    .turn_value_i  (turn_value_i),
    .push_o        (push),
    .item_o        (front_item)
  );

  lstb_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .full_o  (q_full)
  );

  assign back_item = lstb_item_t'(q_data);

  // back: turn state, client table and the table scan
  lstb_back #(
    .MAX_CLIENTS      (MAX_CLIENTS),
    .UPDATES_PER_TURN (UPDATES_PER_TURN),
    .TURN_FIRST       (TURN_FIRST),
    .TURN_LAST        (TURN_LAST)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (q_valid),
    .item_i        (back_item),
    .item_pop_o    (pop),
    .lockstep_en_o (lockstep_en),
    .res_o         (res)
  );

  assign result_valid_o     = res.valid;
  assign update_allowed_o   = res.update_allowed;
  assign turn_now_o         = res.turn_now;
  assign server_done_turn_o = res.server_done_turn;
  assign all_ready_o        = res.all_ready;
  assign turn_report_o      = res.turn_report;

endmodule

[rtl/core/lstb_checker.sv]
module lstb_checker #(
  parameter int unsigned TURN_FIRST = 3,
  parameter int unsigned TURN_LAST  = 50
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        result_valid_o,
  input  logic                        update_allowed_o,
  input  logic [lstb_pkg::TURN_W-1:0] turn_now_o,
  input  logic                        all_ready_o,
  input  logic                        turn_report_o
);
  import lstb_pkg::*;

  localparam logic [TURN_W-1:0] T_FIRST = TURN_W'(TURN_FIRST);
  localparam logic [TURN_W-1:0] T_LAST  = TURN_W'(TURN_LAST);

  // pulses only ride on a result
  a_pulse_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !all_ready_o && !turn_report_o)
    else $error("ready pulse without result");

  // a node is either server or client for a given command
  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(all_ready_o && turn_report_o))
    else $error("both ready pulses at once");

  // an announced turn starts a fresh turn with no updates used
  a_announce_opens_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_ready_o |-> update_allowed_o)
    else $error("new turn without update budget");

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (turn_now_o >= T_FIRST) && (turn_now_o <= T_LAST))
    else $error("turn number out of range");

  // busy only rises after a command transfer
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

endmodule

bind lockstep_turn_barrier_unit lstb_checker #(
  .TURN_FIRST (TURN_FIRST),
  .TURN_LAST  (TURN_LAST)
) u_lstb_checker (.*);

[tb/lockstep_turn_barrier_unit_tb.sv]
module lockstep_turn_barrier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lstb_pkg::*;

  localparam int unsigned MAX_CLIENTS      = 16;
  localparam int unsigned UPDATES_PER_TURN = 6;
  localparam int unsigned TURN_FIRST       = 3;
  localparam int unsigned TURN_LAST        = 50;

  // cycles without any transfer or result before the run is declared hung;
  // worst honest stretch is a sender gap plus a full table scan
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_SHOWN   = 10;

  // codes with no package constant: the no-op the package enumerates, and the spare code
  localparam logic [CMD_W-1:0] CMD_NOP     = CMD_W'(OP_NOP);
  localparam logic [CMD_W-1:0] CMD_SPARE   = 3'd7;
  localparam logic             ROLE_CLIENT = ~ROLE_SERVER;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              paused;
    logic [SLOT_W-1:0] slot;
    logic [TURN_W-1:0] turn_value;
    logic              drain_first;  // hold this command back until all results are in
  } barrier_cmd_t;

  // ---------------------------------------------------------------------------
  // DUT ports
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      cmd_i;
  logic                  paused_i;
  logic [SLOT_W-1:0]     client_slot_i;
  logic [TURN_W-1:0]     turn_value_i;
  logic                  result_valid_o;
  logic                  update_allowed_o;
  logic [TURN_W-1:0]     turn_now_o;
  logic [TURN_W-1:0]     server_done_turn_o;
  logic                  all_ready_o;
  logic                  turn_report_o;

  lockstep_turn_barrier_unit #(
    .MAX_CLIENTS     (MAX_CLIENTS),
    .UPDATES_PER_TURN(UPDATES_PER_TURN),
    .TURN_FIRST      (TURN_FIRST),
    .TURN_LAST       (TURN_LAST)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .paused_i           (paused_i),
    .client_slot_i      (client_slot_i),
    .turn_value_i       (turn_value_i),
    .result_valid_o     (result_valid_o),
    .update_allowed_o   (update_allowed_o),
    .turn_now_o         (turn_now_o),
    .server_done_turn_o (server_done_turn_o),
    .all_ready_o        (all_ready_o),
    .turn_report_o      (turn_report_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Barrier shadow: configuration and state as the block should hold them
  // ---------------------------------------------------------------------------
  logic                  lock_en;
  logic                  node_role_q;
  logic [TICK_W-1:0]     tick_limit;
  logic [CCNT_W-1:0]     cli_cnt;

  logic [TURN_W-1:0]     turn_q;
  logic                  tmr_run;
  logic [TICK_W-1:0]     tmr_ticks;
  logic [2:0]            upd_cnt;
  logic [TURN_W-1:0]     srv_done;
  logic [TURN_W-1:0]     done_tbl [MAX_CLIENTS];

  barrier_cmd_t cmds_to_send [$];
  lstb_res_t    outcomes_due [$];

  int unsigned n_pushed     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_results    = 0;
  int unsigned err_cnt      = 0;
  int unsigned stall_cycles = 0;
  logic        cmd_taken;
  logic        hold_for_drain = 1'b0;
  int          burst_left = 1;
  int          gap_left   = 0;

  function automatic logic update_ok();
    return !lock_en || (upd_cnt < UPDATES_PER_TURN);
  endfunction

  // timer expired, all updates in, and not already declared
  function automatic logic turn_over();
    return tmr_run && (tmr_ticks >= tick_limit) && (upd_cnt == UPDATES_PER_TURN) &&
           (srv_done != turn_q);
  endfunction

  function automatic void advance_turn();
    turn_q    = (turn_q < TURN_LAST) ? turn_q + 1'b1 : TURN_W'(TURN_FIRST);
    upd_cnt   = '0;
    tmr_run   = 1'b1;
    tmr_ticks = '0;
  endfunction

  // Applies one command to the shadow and returns the result it must produce.
  function automatic lstb_res_t step_barrier(input barrier_cmd_t it);
    lstb_res_t   r;
    int unsigned n_cli;
    int unsigned n_ready;
    r = '0;
    if (it.cmd == CMD_UPDATE) begin
      r.update_allowed = update_ok();
      if (r.update_allowed && lock_en) upd_cnt = upd_cnt + 1'b1;
    end else begin
      if (lock_en) begin
        case (it.cmd)
          CMD_TICK: begin
            // the timer counts even on a paused tick
            if (tmr_run && tmr_ticks != '1) tmr_ticks = tmr_ticks + 1'b1;
            if (node_role_q == ROLE_SERVER) begin
              if (!it.paused) begin
                if (turn_over()) begin
                  tmr_run     = 1'b0;
                  tmr_ticks   = '0;
                  done_tbl[0] = turn_q;
                end
                if (!tmr_run && srv_done != turn_q) begin
                  // oversized count clamps; a count of zero passes at once
                  n_cli   = (cli_cnt > MAX_CLIENTS) ? MAX_CLIENTS : cli_cnt;
                  n_ready = 0;
                  for (int unsigned i = 0; i < n_cli; i++)
                    if (done_tbl[i] == turn_q) n_ready++;
                  if (n_ready == n_cli) begin
                    srv_done    = turn_q;
                    r.all_ready = 1'b1;
                  end
                end
                if (srv_done == turn_q) advance_turn();
              end
            end else begin
              if (turn_over()) begin
                tmr_run       = 1'b0;
                tmr_ticks     = '0;
                r.turn_report = 1'b1;
              end
              if (srv_done == turn_q) advance_turn();
            end
          end
          CMD_REPORT: begin
            if (it.slot < MAX_CLIENTS) done_tbl[it.slot] = it.turn_value;
          end
          CMD_ANNOUNCE: srv_done = it.turn_value;
          CMD_START: begin
            tmr_run   = 1'b1;
            tmr_ticks = '0;
          end
          CMD_RESYNC: begin
            // table untouched, limit back to its reset value
            tmr_run    = 1'b0;
            tmr_ticks  = '0;
            turn_q     = TURN_W'(TURN_FIRST);
            srv_done   = '0;
            upd_cnt    = '0;
            tick_limit = LIMIT_RESET;
          end
          default: ;
        endcase
      end
      r.update_allowed = update_ok();
    end
    r.valid            = 1'b1;
    r.turn_now         = turn_q;
    r.server_done_turn = srv_done;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending commands at the falling edge, in bursts with gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_cmds
    barrier_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmds_to_send.size() != 0 &&
                   !(cmds_to_send[0].drain_first && outcomes_due.size() != 0)) begin
        nxt = cmds_to_send.pop_front();
        cmd_i         <= nxt.cmd;
        paused_i      <= nxt.paused;
        client_slot_i <= nxt.slot;
        turn_value_i  <= nxt.turn_value;
        start         <= 1'b1;
        if (burst_left <= 1) begin
          // mostly short gaps, sometimes none, now and then a long one
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 2);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results and predicts each accepted command at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    lstb_res_t    want;
    barrier_cmd_t seen;
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      if (result_valid_o) begin
        n_results++;
        if (outcomes_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("%0t: result %0d arrived with nothing outstanding", $realtime, n_results);
        end else begin
          want = outcomes_due.pop_front();
          if (want.update_allowed   !== update_allowed_o   ||
              want.turn_now         !== turn_now_o         ||
              want.server_done_turn !== server_done_turn_o ||
              want.all_ready        !== all_ready_o        ||
              want.turn_report      !== turn_report_o) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display({"%0t: result %0d mismatch: expected allowed=%0b turn=%0d done=%0d ",
                        "srv_rdy=%0b cli_rdy=%0b, got allowed=%0b turn=%0d done=%0d ",
                        "srv_rdy=%0b cli_rdy=%0b"}, $realtime, n_results,
                       want.update_allowed, want.turn_now, want.server_done_turn,
                       want.all_ready, want.turn_report,
                       update_allowed_o, turn_now_o, server_done_turn_o,
                       all_ready_o, turn_report_o);
          end
        end
      end
      if (start && !busy) begin
        seen = '{cmd: cmd_i, paused: paused_i, slot: client_slot_i,
                 turn_value: turn_value_i, drain_first: 1'b0};
        outcomes_due.push_back(step_barrier(seen));
        n_accepted++;
      end
      cmd_taken    <= start && !busy;
      stall_cycles <= (result_valid_o || (start && !busy)) ? 0 : stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic p,
                           input logic [SLOT_W-1:0] s, input logic [TURN_W-1:0] tv);
    barrier_cmd_t it;
    it = '{cmd: c, paused: p, slot: s, turn_value: tv,
           drain_first: hold_for_drain || ($urandom_range(0, 149) == 0)};
    hold_for_drain = 1'b0;
    cmds_to_send.push_back(it);
    n_pushed++;
  endtask

  task automatic queue_noise();
    logic [CMD_W-1:0] c;
    c = CMD_W'($urandom_range(0, 7));
    // resync throws the turn away, keep it rare
    if (c == CMD_RESYNC && $urandom_range(0, 9) != 0) c = CMD_TICK;
    queue_cmd(c, 1'($urandom), SLOT_W'($urandom), TURN_W'($urandom));
  endtask

  // Returns just after a rising edge once every queued command is transferred,
  // and, when idle is set, every result is back. The shadow is then current.
  task automatic sync_state(input logic idle);
    do begin
      @(posedge clk_i);
      #0.1;
    end while (n_accepted != n_pushed || (idle && outcomes_due.size() != 0));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ENABLE: lock_en     = val[0];
      CFG_ROLE:   node_role_q = val[0];
      CFG_LIMIT:  tick_limit  = val;
      CFG_COUNT:  cli_cnt     = val[CCNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Register writes only with the block idle; upper data bits carry junk
  task automatic set_config(input logic en, input logic role,
                            input logic [TICK_W-1:0] lim, input logic [CCNT_W-1:0] cnt);
    sync_state(1'b1);
    write_reg(CFG_ENABLE, {15'($urandom), en});
    write_reg(CFG_ROLE,   {15'($urandom), role});
    write_reg(CFG_LIMIT,  lim);
    write_reg(CFG_COUNT,  {11'($urandom), cnt});
    @(posedge clk_i);
    #0.1;
  endtask

  // One turn worth of well-formed traffic built on the present shadow state:
  // start if stopped, updates interleaved with client reports, enough ticks to
  // expire a small-limit timer, and for a client the server's announce plus a tick.
  task automatic turn_episode();
    int unsigned      n_cli;
    int               ups;
    int               reps;
    int unsigned      ticks;
    logic [SLOT_W-1:0] rep_slot;
    sync_state(1'b0);
    if (!lock_en || $urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 6)) queue_noise();
    end else begin
      n_cli = (cli_cnt > MAX_CLIENTS) ? MAX_CLIENTS : cli_cnt;
      if (!tmr_run && $urandom_range(0, 7) != 0)
        queue_cmd(CMD_START, 1'($urandom), SLOT_W'($urandom), TURN_W'($urandom));
      ups      = UPDATES_PER_TURN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      reps     = (node_role_q == ROLE_SERVER && n_cli > 1) ? n_cli - 1 : 0;
      rep_slot = SLOT_W'(1);
      while (ups + reps > 0) begin
        if (ups > 0 && (reps == 0 || $urandom_range(0, 1) == 1)) begin
          queue_cmd(CMD_UPDATE, 1'($urandom), SLOT_W'($urandom), TURN_W'($urandom));
          ups--;
        end else begin
          queue_cmd(CMD_REPORT, 1'($urandom), rep_slot,
                    ($urandom_range(0, 15) == 0) ? TURN_W'($urandom) : turn_q);
          rep_slot++;
          reps--;
        end
        if ($urandom_range(0, 19) == 0) queue_noise();
      end
      ticks = (tick_limit <= 6) ? tick_limit + $urandom_range(1, 3) : $urandom_range(1, 4);
      repeat (ticks)
        queue_cmd(CMD_TICK, $urandom_range(0, 5) == 0, SLOT_W'($urandom), TURN_W'($urandom));
      if (node_role_q == ROLE_CLIENT) begin
        queue_cmd(CMD_ANNOUNCE, 1'($urandom), SLOT_W'($urandom),
                  ($urandom_range(0, 9) == 0) ? TURN_W'($urandom) : turn_q);
        queue_cmd(CMD_TICK, 1'($urandom), SLOT_W'($urandom), TURN_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int unsigned n_cmds);
    int unsigned goal;
    goal = n_pushed + n_cmds;
    while (n_pushed < goal) turn_episode();
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : hang_guard
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("lockstep_turn_barrier_unit_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    start         = 1'b0;
    cmd_i         = '0;
    paused_i      = 1'b0;
    client_slot_i = '0;
    turn_value_i  = '0;
    lock_en       = 1'b1;
    node_role_q   = ROLE_SERVER;
    tick_limit    = LIMIT_RESET;
    cli_cnt       = COUNT_RESET;
    turn_q        = TURN_W'(TURN_FIRST);
    tmr_run       = 1'b0;
    tmr_ticks     = '0;
    upd_cnt       = '0;
    srv_done      = '0;
    foreach (done_tbl[i]) done_tbl[i] = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #0.1;

    // Directed part, reset configuration (server, one client, limit 200).
    // Seventh update of the turn is refused.
    repeat (UPDATES_PER_TURN + 1)
      queue_cmd(CMD_UPDATE, 1'($urandom), SLOT_W'($urandom), TURN_W'($urandom));
    // paused tick, then a scan that fails and one that passes on the server's own entry
    queue_cmd(CMD_TICK, 1'b1, '1, '1);
    queue_cmd(CMD_TICK, 1'b0, '0, '0);
    queue_cmd(CMD_REPORT, 1'b0, '0, TURN_W'(TURN_FIRST));
    queue_cmd(CMD_TICK, 1'b0, '0, '0);
    queue_cmd(CMD_START, 1'b1, '1, '1);
    queue_cmd(CMD_REPORT, 1'b1, '1, '1);
    queue_cmd(CMD_REPORT, 1'b0, '0, '0);
    // sender waits here until the pipeline is empty
    hold_for_drain = 1'b1;
    queue_cmd(CMD_ANNOUNCE, 1'b0, '0, '1);
    // announce of the current turn lets the next tick advance
    queue_cmd(CMD_ANNOUNCE, 1'b1, '1, TURN_W'(TURN_FIRST + 1));
    queue_cmd(CMD_TICK, 1'b0, '0, '0);
    queue_cmd(CMD_NOP, 1'b1, '1, '1);
    queue_cmd(CMD_SPARE, 1'b0, '0, '0);
    queue_cmd(CMD_UPDATE, 1'b0, '0, '0);
    queue_cmd(CMD_RESYNC, 1'b1, '1, '1);
    queue_cmd(CMD_TICK, 1'b1, '0, '0);
    queue_cmd(CMD_START, 1'b0, '0, '0);
    queue_cmd(CMD_TICK, 1'b0, '1, '1);

    // Random part over a range of settings; tiny tick limits keep turns short
    set_config(1'b1, ROLE_SERVER, 16'd0, 5'd1);
    run_phase(200);
    set_config(1'b1, ROLE_SERVER, 16'd1, 5'd16);   // full table scan
    run_phase(150);
    set_config(1'b1, ROLE_SERVER, 16'd2, 5'd31);   // count clamps to table size
    run_phase(100);
    set_config(1'b1, ROLE_SERVER, 16'd0, 5'd0);    // empty table, ready at once
    run_phase(100);
    set_config(1'b1, ROLE_CLIENT, 16'd0, 5'd1);    // long enough to wrap the turn
    run_phase(450);
    set_config(1'b0, ROLE_CLIENT, 16'd3, 5'd4);    // gating off
    run_phase(60);
    set_config(1'b1, ROLE_SERVER, 16'hFFFF, 5'd5); // turns never expire
    run_phase(60);
    repeat (4) begin
      set_config($urandom_range(0, 4) != 0, 1'($urandom),
                 ($urandom_range(0, 1) == 1) ? TICK_W'($urandom_range(0, 3)) : TICK_W'($urandom),
                 CCNT_W'($urandom));
      run_phase(50);
    end

    sync_state(1'b1);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    #0.1;
    if (err_cnt == 0 && outcomes_due.size() == 0) begin
      $display("lockstep_turn_barrier_unit_tb: clean");
    end else begin
      $display("lockstep_turn_barrier_unit_tb: errors");
    end
    $finish;
  end

endmodule
